/* src/bbc_pkg.sv */
// Shared types, constants and register codes of the bitmap blitter.
package bbc_pkg;

   localparam int ADDR_WIDTH = 16;
   localparam int PROD_WIDTH = 17;
   localparam logic [PROD_WIDTH-1:0] ADDR_MASK = PROD_WIDTH'((1 << ADDR_WIDTH) - 1);

   typedef enum logic [2:0] {
      CSR_DEST_X         = 3'd0,
      CSR_DEST_Y         = 3'd1,
      CSR_WIDTH_BITS     = 3'd2,
      CSR_ROW_COUNT      = 3'd3,
      CSR_CLEAR_MODE     = 3'd4,
      CSR_BYTES_PER_LINE = 3'd5,
      CSR_SCREEN_LINES   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] dest_x;
      logic [7:0] dest_y;
      logic [7:0] width_bits;
      logic [7:0] row_count;
      logic       clear_mode;
      logic [7:0] bytes_per_line;
      logic [7:0] screen_lines;
   } cfg_type;

   typedef struct packed {
      logic       busy;
      logic       load;
      logic [7:0] start_row;
   } ctrl_type;

   typedef struct packed {
      logic [15:0] screen_address;
      logic [7:0]  bit_mask;
      logic        clear_bits;
      logic        end_of_run;
      logic        end_of_blit;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic       two;
      result_type first;
      result_type second;
   } push_type;

endpackage

/* src/bbc_req_if.sv */
// Handshake channel that carries bitmap bytes into the blitter.
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] bitmap_byte;

   modport source (output valid, output bitmap_byte, input ready);
   modport sink (input valid, input bitmap_byte, output ready);
endinterface

/* src/bbc_rsp_if.sv */
// Handshake channel that carries frame buffer update commands out of the blitter.
interface bbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] screen_address;
   logic [7:0]  bit_mask;
   logic        clear_bits;
   logic        end_of_run;
   logic        end_of_blit;

   modport source (output valid, output screen_address, output bit_mask,
                   output clear_bits, output end_of_run, output end_of_blit, input ready);
   modport sink (input valid, input screen_address, input bit_mask,
                 input clear_bits, input end_of_run, input end_of_blit, output ready);
endinterface

/* src/bbc_csr.sv */
// Configuration registers and the serial unit that reduces the start row modulo the screen height.
module bbc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   output bbc_pkg::cfg_type    cfg,
   output bbc_pkg::ctrl_type   ctrl
);

   bbc_pkg::cfg_type cfg_ff, cfg_in;
   logic             hit;
   logic             busy_ff;
   logic             load_ff;
   logic [2:0]       step_ff;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       start_row_ff;
   logic [8:0]       trial;
   logic [8:0]       eff_lines;

   always_comb begin
      cfg_in = cfg_ff;
      hit = 1'b0;
      if (csr_wr_en) begin
         unique case (bbc_pkg::csr_index_type'(csr_index))
            bbc_pkg::CSR_DEST_X: begin
               cfg_in.dest_x = csr_wdata;
               hit = 1'b1;
            end
            bbc_pkg::CSR_DEST_Y: begin
               cfg_in.dest_y = csr_wdata;
               hit = 1'b1;
            end
            bbc_pkg::CSR_WIDTH_BITS: begin
               cfg_in.width_bits = csr_wdata;
               hit = 1'b1;
            end
            bbc_pkg::CSR_ROW_COUNT: begin
               cfg_in.row_count = csr_wdata;
               hit = 1'b1;
            end
            bbc_pkg::CSR_CLEAR_MODE: begin
               cfg_in.clear_mode = csr_wdata[0];
               hit = 1'b1;
            end
            bbc_pkg::CSR_BYTES_PER_LINE: begin
               cfg_in.bytes_per_line = csr_wdata;
               hit = 1'b1;
            end
            bbc_pkg::CSR_SCREEN_LINES: begin
               cfg_in.screen_lines = csr_wdata;
               hit = 1'b1;
            end
            default: begin
               hit = 1'b0;
            end
         endcase
      end
   end

   // One quotient bit per cycle of a restoring division; only the remainder is kept.
   always_comb begin
      eff_lines = {(cfg_ff.screen_lines == 8'd0), cfg_ff.screen_lines};
      trial = {rem_ff, cfg_ff.dest_y[~step_ff]};
      rem_in = (trial >= eff_lines) ? 8'(trial - eff_lines) : trial[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x <= 8'd0;
         cfg_ff.dest_y <= 8'd0;
         cfg_ff.width_bits <= 8'd8;
         cfg_ff.row_count <= 8'd1;
         cfg_ff.clear_mode <= 1'b0;
         cfg_ff.bytes_per_line <= 8'd16;
         cfg_ff.screen_lines <= 8'd96;
         busy_ff <= 1'b0;
         load_ff <= 1'b0;
         step_ff <= 3'd0;
         rem_ff <= 8'd0;
         start_row_ff <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
         load_ff <= 1'b0;
         if (hit) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
            rem_ff <= 8'd0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               busy_ff <= 1'b0;
               load_ff <= 1'b1;
               start_row_ff <= rem_in;
            end
         end
      end
   end

   assign cfg = cfg_ff;
   assign ctrl.busy = busy_ff;
   assign ctrl.load = load_ff;
   assign ctrl.start_row = start_row_ff;

endmodule

/* src/bbc_gen.sv */
// Input register, blit position state and the logic that forms the update commands.
module bbc_gen (
   input  logic               clock,
   input  logic               reset,
   input  bbc_pkg::cfg_type   cfg,
   input  bbc_pkg::ctrl_type  ctrl,
   bbc_req_if.sink            req_bus,
   input  logic [1:0]         space,
   output bbc_pkg::push_type  push
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic [4:0] byte_in_row_ff;
   logic [7:0] row_index_ff;
   logic [7:0] column_ff;
   logic [7:0] row_ff;

   logic [2:0]  shift;
   logic        two;
   logic        fire;
   logic [8:0]  eff_bpl;
   logic [8:0]  eff_lines;
   logic [8:0]  width_up;
   logic [4:0]  last_byte;
   logic [7:0]  last_row;
   logic        row_end;
   logic        blit_end;
   logic [8:0]  col_inc;
   logic [7:0]  col2;
   logic [8:0]  row_inc;
   logic [7:0]  row_next;
   logic [16:0] prod;
   logic [16:0] addr1;
   logic [16:0] addr2;
   logic [15:0] spread;

   always_comb begin
      shift = cfg.dest_x[2:0];
      two = (shift != 3'd0);
      fire = valid_ff && (two ? (space == 2'd2) : (space != 2'd0));
      eff_bpl = {(cfg.bytes_per_line == 8'd0), cfg.bytes_per_line};
      eff_lines = {(cfg.screen_lines == 8'd0), cfg.screen_lines};
      width_up = {1'b0, cfg.width_bits} + 9'd7;
      last_byte = 5'(width_up[8:3] - 6'd1);
      last_row = cfg.row_count - 8'd1;
      row_end = (byte_in_row_ff == last_byte);
      blit_end = row_end && (row_index_ff == last_row);
      col_inc = {1'b0, column_ff} + 9'd1;
      col2 = (col_inc >= eff_bpl) ? 8'd0 : col_inc[7:0];
      row_inc = {1'b0, row_ff} + 9'd1;
      row_next = (row_inc >= eff_lines) ? 8'd0 : row_inc[7:0];
      prod = {9'd0, row_ff} * {8'd0, eff_bpl};
      addr1 = (prod + {9'd0, column_ff}) & bbc_pkg::ADDR_MASK;
      addr2 = (prod + {9'd0, col2}) & bbc_pkg::ADDR_MASK;
      spread = {byte_ff, 8'd0} >> shift;

      push.valid = fire;
      push.two = two;
      push.first.screen_address = addr1[15:0];
      push.first.bit_mask = spread[15:8];
      push.first.clear_bits = cfg.clear_mode;
      push.first.end_of_run = !two;
      push.first.end_of_blit = blit_end && !two;
      push.second.screen_address = addr2[15:0];
      push.second.bit_mask = spread[7:0];
      push.second.clear_bits = cfg.clear_mode;
      push.second.end_of_run = 1'b1;
      push.second.end_of_blit = blit_end;
   end

   assign req_bus.ready = !ctrl.busy && !ctrl.load && (!valid_ff || fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         byte_ff <= req_bus.bitmap_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_row_ff <= 5'd0;
         row_index_ff <= 8'd0;
         column_ff <= 8'd0;
         row_ff <= 8'd0;
      end else if (ctrl.load || (fire && blit_end)) begin
         byte_in_row_ff <= 5'd0;
         row_index_ff <= 8'd0;
         column_ff <= {3'd0, cfg.dest_x[7:3]};
         row_ff <= ctrl.start_row;
      end else if (fire && row_end) begin
         byte_in_row_ff <= 5'd0;
         row_index_ff <= row_index_ff + 8'd1;
         column_ff <= {3'd0, cfg.dest_x[7:3]};
         row_ff <= row_next;
      end else if (fire) begin
         byte_in_row_ff <= byte_in_row_ff + 5'd1;
         column_ff <= col2;
      end
   end

endmodule

/* src/bbc_outq.sv */
// Two-entry result queue that drives the update command channel.
module bbc_outq (
   input  logic               clock,
   input  logic               reset,
   input  bbc_pkg::push_type  push,
   output logic [1:0]         space,
   bbc_rsp_if.source          rsp_bus
);

   bbc_pkg::result_type slot0_ff, slot0_in;
   bbc_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;
   logic [1:0]          remain;

   always_comb begin
      pop = (count_ff != 2'd0) && rsp_bus.ready;
      remain = count_ff - {1'b0, pop};
      space = 2'd2 - remain;
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      count_in = remain;
      if (push.valid) begin
         count_in = remain + (push.two ? 2'd2 : 2'd1);
         if (remain == 2'd0) begin
            slot0_in = push.first;
            slot1_in = push.second;
         end else begin
            slot1_in = push.first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_bus.valid = (count_ff != 2'd0);
   assign rsp_bus.screen_address = slot0_ff.screen_address;
   assign rsp_bus.bit_mask = slot0_ff.bit_mask;
   assign rsp_bus.clear_bits = slot0_ff.clear_bits;
   assign rsp_bus.end_of_run = slot0_ff.end_of_run;
   assign rsp_bus.end_of_blit = slot0_ff.end_of_blit;

endmodule

/* src/bitmap_blit_or_clear_top.sv */
// Top level of the one-bit bitmap blitter with sub-byte shift.
//
//   Channel   Direction  Transfer
//   req_bus   in         one bitmap byte per transfer
//   rsp_bus   out        one masked frame buffer update per transfer
//   csr_*     in         one register write per cycle with csr_wr_en high
//
// A byte yields one update when dest_x is a multiple of eight and two updates otherwise;
// input is paced by the single result channel, which carries one update per transfer.
// Each byte passes through the input register and then the result queue before rsp_bus.
// Reset is synchronous; every accepted register write holds off input while the start row
// is reduced modulo the screen height, one bit per cycle, and while the result is loaded.
// A stalled result channel fills the two-entry result queue and then stalls the input.
module bitmap_blit_or_clear_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   bbc_req_if.sink    req_bus,
   bbc_rsp_if.source  rsp_bus
);

   bbc_pkg::cfg_type  cfg;
   bbc_pkg::ctrl_type ctrl;
   bbc_pkg::push_type push;
   logic [1:0]        space;

   bbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .ctrl      (ctrl)
   );

   bbc_gen u_gen (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .ctrl    (ctrl),
      .req_bus (req_bus),
      .space   (space),
      .push    (push)
   );

   bbc_outq u_outq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .space   (space),
      .rsp_bus (rsp_bus)
   );

endmodule
